// File: sv/modular_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Modular arithmetic unit assertion macros
// Shared forms for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Widths, command codes, datapath micro-ops and controller states.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int W     = 31;
  localparam int CNT_W = $clog2(W);

  typedef logic [W-1:0] word_t;
  typedef logic [3:0]   cmd_t;

  localparam cmd_t CMD_REDUCE = 4'd0;
  localparam cmd_t CMD_ADD    = 4'd1;
  localparam cmd_t CMD_SUB    = 4'd2;
  localparam cmd_t CMD_MUL    = 4'd3;
  localparam cmd_t CMD_DIV    = 4'd4;
  localparam cmd_t CMD_INV    = 4'd5;
  localparam cmd_t CMD_NEG    = 4'd6;
  localparam cmd_t CMD_INC    = 4'd7;
  localparam cmd_t CMD_DEC    = 4'd8;
  localparam cmd_t CMD_CMP    = 4'd9;

  // Datapath micro-ops issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,   // latch command and operands
    OP_DIVA,   // start divider on raw a by modulus
    OP_DIVB,   // start divider on raw b by modulus
    OP_DIVQ,   // start divider on r0 by r1
    OP_DSTEP,  // one restoring division step
    OP_SETA,   // a <= remainder
    OP_SETB,   // b <= remainder
    OP_INVA,   // Euclid init on a
    OP_INVB,   // Euclid init on b
    OP_MULA,   // start a*b mod m
    OP_MULQ,   // start (q mod m)*t1 mod m
    OP_MULD,   // start a*t0 mod m
    OP_MSTEP,  // one shift-add step
    OP_EUPD,   // Euclid row update
    OP_ALU     // form the result into the output register
  } dp_op_t;

  typedef struct packed {
    logic last;     // counter on its final step
    logic r1_zero;
    logic r0_one;
    cmd_t cmd;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RA_GO,
    S_RA,
    S_RA_SAVE,
    S_RB_GO,
    S_RB,
    S_RB_SAVE,
    S_DISP,
    S_MUL,
    S_INV_CHK,
    S_EDIV,
    S_EMUL_GO,
    S_EMUL,
    S_EUPD,
    S_DMUL,
    S_FIN
  } ctl_state_t;

endpackage

// File: sv/mau_in_if.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit input channel
// Valid/ready channel carrying a command and two operands.
// ----------------------------------------------------------------------------
interface mau_in_if import mau_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  word_t operand_a;
  word_t operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

// File: sv/mau_out_if.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit result channel
// Valid/ready channel carrying a residue and three flags.
// ----------------------------------------------------------------------------
interface mau_out_if import mau_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t result;
  logic  less;
  logic  equal;
  logic  error;

  modport source (output valid, result, less, equal, error, input ready);
  modport sink   (input valid, result, less, equal, error, output ready);
endinterface

// File: sv/mau_datapath.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit datapath
// Modulus register, restoring divider, shift-add modular multiplier,
// Euclid rows and the output register, all driven by micro-ops.
// ----------------------------------------------------------------------------
module mau_datapath import mau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  word_t      cfg_wdata,
  input  cmd_t       in_cmd,
  input  word_t      in_a,
  input  word_t      in_b,
  input  dp_op_t     op,
  output dp_status_t status,
  output word_t      result,
  output logic       less,
  output logic       equal,
  output logic       error
);

  word_t mod_r;
  cmd_t  cmd_r;
  word_t araw_r, braw_r, a_r, b_r;
  word_t d_r, rem_r, quo_r;
  word_t r0_r, r1_r, t0_r, t1_r;
  word_t acc_r, mx_r, my_r;
  logic [CNT_W-1:0] cnt_r;
  word_t res_r;
  logic  lt_r, eq_r, err_r;

  word_t m, one, qmod, rem_nxt;
  logic [W:0] tmp;
  logic  ge;
  word_t alu_res;
  logic  alu_lt, alu_eq, alu_err;

  function automatic word_t add_mod(word_t x, word_t y, word_t md);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  function automatic word_t sub_mod(word_t x, word_t y, word_t md);
    logic [W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, md} - {1'b0, y};
    return s[W-1:0];
  endfunction

  assign m    = (mod_r == '0) ? word_t'(1) : mod_r;
  assign one  = (m == word_t'(1)) ? '0 : word_t'(1);
  assign qmod = (quo_r == m) ? '0 : quo_r;

  // Restoring division step
  assign tmp     = {rem_r, quo_r[W-1]};
  assign ge      = tmp >= {1'b0, d_r};
  assign rem_nxt = ge ? W'(tmp - {1'b0, d_r}) : tmp[W-1:0];

  always_comb begin
    alu_res = '0;
    alu_lt  = 1'b0;
    alu_eq  = 1'b0;
    alu_err = 1'b0;
    case (cmd_r)
      CMD_REDUCE: alu_res = a_r;
      CMD_ADD:    alu_res = add_mod(a_r, b_r, m);
      CMD_SUB:    alu_res = sub_mod(a_r, b_r, m);
      CMD_MUL:    alu_res = acc_r;
      CMD_DIV: begin
        alu_err = (r0_r != word_t'(1));
        alu_res = alu_err ? '0 : acc_r;
      end
      CMD_INV: begin
        alu_err = (r0_r != word_t'(1));
        alu_res = alu_err ? '0 : t0_r;
      end
      CMD_NEG:    alu_res = sub_mod('0, a_r, m);
      CMD_INC:    alu_res = add_mod(a_r, one, m);
      CMD_DEC:    alu_res = sub_mod(a_r, one, m);
      CMD_CMP: begin
        alu_lt = a_r < b_r;
        alu_eq = a_r == b_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= word_t'(1);
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        cmd_r  <= in_cmd;
        araw_r <= in_a;
        braw_r <= in_b;
      end
      OP_DIVA: begin
        d_r <= m; rem_r <= '0; quo_r <= araw_r; cnt_r <= '0;
      end
      OP_DIVB: begin
        d_r <= m; rem_r <= '0; quo_r <= braw_r; cnt_r <= '0;
      end
      OP_DIVQ: begin
        d_r <= r1_r; rem_r <= '0; quo_r <= r0_r; cnt_r <= '0;
      end
      OP_DSTEP: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      OP_SETA: a_r <= rem_r;
      OP_SETB: b_r <= rem_r;
      OP_INVA: begin
        r0_r <= m; r1_r <= a_r; t0_r <= '0; t1_r <= one;
      end
      OP_INVB: begin
        r0_r <= m; r1_r <= b_r; t0_r <= '0; t1_r <= one;
      end
      OP_MULA: begin
        acc_r <= '0; mx_r <= a_r; my_r <= b_r; cnt_r <= '0;
      end
      OP_MULQ: begin
        acc_r <= '0; mx_r <= qmod; my_r <= t1_r; cnt_r <= '0;
      end
      OP_MULD: begin
        acc_r <= '0; mx_r <= a_r; my_r <= t0_r; cnt_r <= '0;
      end
      OP_MSTEP: begin
        if (my_r[0]) acc_r <= add_mod(acc_r, mx_r, m);
        mx_r  <= add_mod(mx_r, mx_r, m);
        my_r  <= my_r >> 1;
        cnt_r <= cnt_r + 1'b1;
      end
      OP_EUPD: begin
        r0_r <= r1_r;
        r1_r <= rem_r;
        t0_r <= t1_r;
        t1_r <= sub_mod(t0_r, acc_r, m);
      end
      OP_ALU: begin
        res_r <= alu_res;
        lt_r  <= alu_lt;
        eq_r  <= alu_eq;
        err_r <= alu_err;
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  assign status.last    = (cnt_r == CNT_W'(W - 1));
  assign status.r1_zero = (r1_r == '0);
  assign status.r0_one  = (r0_r == word_t'(1));
  assign status.cmd     = cmd_r;

  assign result = res_r;
  assign less   = lt_r;
  assign equal  = eq_r;
  assign error  = err_r;

endmodule

// File: sv/mau_controller.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit controller
// Sequences reduction, multiply and extended Euclid on the datapath.
// ----------------------------------------------------------------------------
module mau_controller import mau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output dp_op_t     op
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op            = OP_NOP;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_RA_GO;
        end
      end
      S_RA_GO: begin
        op        = OP_DIVA;
        state_nxt = S_RA;
      end
      S_RA: begin
        op = OP_DSTEP;
        if (status.last) state_nxt = S_RA_SAVE;
      end
      S_RA_SAVE: begin
        op        = OP_SETA;
        state_nxt = S_RB_GO;
      end
      S_RB_GO: begin
        op        = OP_DIVB;
        state_nxt = S_RB;
      end
      S_RB: begin
        op = OP_DSTEP;
        if (status.last) state_nxt = S_RB_SAVE;
      end
      S_RB_SAVE: begin
        op        = OP_SETB;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (status.cmd == CMD_MUL) begin
          op        = OP_MULA;
          state_nxt = S_MUL;
        end else if (status.cmd == CMD_DIV) begin
          op        = OP_INVB;
          state_nxt = S_INV_CHK;
        end else if (status.cmd == CMD_INV) begin
          op        = OP_INVA;
          state_nxt = S_INV_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        op = OP_MSTEP;
        if (status.last) state_nxt = S_FIN;
      end
      S_INV_CHK: begin
        if (status.r1_zero) begin
          if (status.cmd == CMD_DIV && status.r0_one) begin
            op        = OP_MULD;
            state_nxt = S_DMUL;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          op        = OP_DIVQ;
          state_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        op = OP_DSTEP;
        if (status.last) state_nxt = S_EMUL_GO;
      end
      S_EMUL_GO: begin
        op        = OP_MULQ;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        op = OP_MSTEP;
        if (status.last) state_nxt = S_EUPD;
      end
      S_EUPD: begin
        op        = OP_EUPD;
        state_nxt = S_INV_CHK;
      end
      S_DMUL: begin
        op = OP_MSTEP;
        if (status.last) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output slot is free
        if (!out_valid_r || out_ready) begin
          op            = OP_ALU;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Reduce, add, subtract, multiply, divide, invert, negate, increment,
// decrement and compare residues modulo a configured modulus.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------
//  in_ch    | in  | valid/ready       | cmd, operand_a, operand_b
//  out_ch   | out | valid/ready       | result, less, equal, error
//  cfg      | in  | cfg_we (no stall) | cfg_wdata = modulus
//
//  One item at a time. Both operands are reduced by a 1-bit-a-cycle
//  restoring divider, and a multiply is a shift-add loop. Inverse and
//  divide add Euclid rounds of one division and one modular multiply,
//  with up to about 45 rounds for a 31-bit modulus, each round entered
//  through a check step; divide then adds a final modular multiply.
//  Reset clears the controller and sets the modulus to 1. A finished result
//  waits in the output register, and the next item is accepted meanwhile;
//  a stalled output only holds the block in its final step.
//
module modular_arithmetic_unit import mau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  word_t        cfg_wdata,
  mau_in_if.sink       in_ch,
  mau_out_if.source    out_ch
);

  dp_op_t     op;
  dp_status_t status;

  // Sequencer: owns handshakes and the order of micro-ops
  mau_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .op        (op)
  );

  // Arithmetic and the result register
  mau_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (in_ch.cmd),
    .in_a      (in_ch.operand_a),
    .in_b      (in_ch.operand_b),
    .op        (op),
    .status    (status),
    .result    (out_ch.result),
    .less      (out_ch.less),
    .equal     (out_ch.equal),
    .error     (out_ch.error)
  );

endmodule

// File: sv/mau_checker.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Port-level checks on handshakes and result flags, bound to the top.
// ----------------------------------------------------------------------------
`include "modular_arithmetic_unit_assert.svh"

module mau_checker import mau_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t result,
  input logic  less,
  input logic  equal,
  input logic  error
);

  `MAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MAU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while busy")
  `MAU_ASSERT_SAME(a_error_zero, out_valid && error, result == '0, "error with nonzero result")
  `MAU_ASSERT_SAME(a_cmp_excl, out_valid, !(less && equal), "less and equal both set")

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .result    (out_ch.result),
  .less      (out_ch.less),
  .equal     (out_ch.equal),
  .error     (out_ch.error)
);
